// ----- hw/rtl/crc_pkg.sv -----
`default_nettype none
package crc_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned ERR_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned NUM_OCTANTS = 8;
  localparam int unsigned OCT_W = $clog2(NUM_OCTANTS);

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AREA_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT = 3'd5;

  localparam logic [COORD_W-1:0] CLIP_WIDTH_RST = 8'd255;
  localparam logic [COORD_W-1:0] CLIP_HEIGHT_RST = 8'd191;

  // One iteration handed from the front to the back
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               finish;
  } job_t;

  // Origin and clip window as seen by the back
  typedef struct packed {
    logic [COORD_W-1:0] area_x;
    logic [COORD_W-1:0] area_y;
    logic [COORD_W-1:0] clip_left;
    logic [COORD_W-1:0] clip_top;
    logic [COORD_W-1:0] clip_right;
    logic [COORD_W-1:0] clip_bottom;
  } view_t;

endpackage
`default_nettype wire

// ----- hw/rtl/circle_rasterizer_clipped.sv -----
`default_nettype none
// Clipped midpoint circle rasterizer. A start beat (operation 0) latches centre and
// radius and gives no result. Each advance beat while a circle runs gives eight point
// beats in octant order, one per cycle from the output register when not stalled, so
// the back's single point path sets the sustained rate at which advance items drain.
// Items are accepted every cycle until QueueDepth iterations wait in the queue between
// the iteration front and the point back. Advance while idle gives nothing. Points are
// offset by the area origin with 8-bit wrap and flagged visible against the clip window,
// all edges inclusive. Configuration writes are always ready; write only while idle.
module circle_rasterizer_clipped #(
  parameter int unsigned QueueDepth = crc_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          operation_i,
  input  wire logic [crc_pkg::COORD_W-1:0]   center_x_i,
  input  wire logic [crc_pkg::COORD_W-1:0]   center_y_i,
  input  wire logic [crc_pkg::COORD_W-1:0]   radius_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [crc_pkg::COORD_W-1:0]        pixel_x_o,
  output logic [crc_pkg::COORD_W-1:0]        pixel_y_o,
  output logic                               visible_o,
  output logic [crc_pkg::OCT_W-1:0]          octant_o,
  output logic                               last_o,
  output logic                               done_res_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [crc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [crc_pkg::COORD_W-1:0]   cfg_data_i
);
  import crc_pkg::*;

  logic [COORD_W-1:0] area_x_q, area_y_q, left_q, top_q, width_q, height_q;
  logic               push, pop, empty, full, accept;
  job_t               push_job, head_job;
  view_t              view;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = full;
  assign accept = in_valid_i && !in_stall_o;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_x_q <= '0;
      area_y_q <= '0;
      left_q <= '0;
      top_q <= '0;
      width_q <= CLIP_WIDTH_RST;
      height_q <= CLIP_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_AREA_X:      area_x_q <= cfg_data_i;
        REG_AREA_Y:      area_y_q <= cfg_data_i;
        REG_CLIP_LEFT:   left_q <= cfg_data_i;
        REG_CLIP_TOP:    top_q <= cfg_data_i;
        REG_CLIP_WIDTH:  width_q <= cfg_data_i;
        REG_CLIP_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window edges wrap at 8 bits
  assign view.area_x = area_x_q;
  assign view.area_y = area_y_q;
  assign view.clip_left = left_q;
  assign view.clip_top = top_q;
  assign view.clip_right = left_q + width_q - COORD_W'(1);
  assign view.clip_bottom = top_q + height_q - COORD_W'(1);

  crc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .push_o      (push),
    .job_o       (push_job)
  );

  crc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (empty),
    .full_o      (full)
  );

  crc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (!empty),
    .pop_o       (pop),
    .view_i      (view),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .visible_o   (visible_o),
    .octant_o    (octant_o),
    .last_o      (last_o),
    .done_res_o  (done_res_o)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/crc_front.sv -----
`default_nettype none
module crc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic                        operation_i,
  input  wire logic [crc_pkg::COORD_W-1:0] center_x_i,
  input  wire logic [crc_pkg::COORD_W-1:0] center_y_i,
  input  wire logic [crc_pkg::COORD_W-1:0] radius_i,
  output logic                             push_o,
  output crc_pkg::job_t                    job_o
);
  import crc_pkg::*;

  logic [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d, x_q, x_d, y_q, y_d;
  logic [ERR_W-1:0]   err_q, err_d, err_step;
  logic               active_q, active_d, finish;

  assign finish = (x_q <= y_q);
  assign push_o = accept_i && (operation_i == OP_ADVANCE) && active_q;

  assign job_o.cx = cx_q;
  assign job_o.cy = cy_q;
  assign job_o.x = x_q;
  assign job_o.y = y_q;
  assign job_o.finish = finish;

  // Midpoint step: add 2y+1, pull x in when the error passes x
  assign err_step = err_q + {{(ERR_W-COORD_W-1){1'b0}}, y_q, 1'b1};

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    x_d = x_q;
    y_d = y_q;
    err_d = err_q;
    active_d = active_q;
    if (accept_i && operation_i == OP_START) begin
      cx_d = center_x_i;
      cy_d = center_y_i;
      x_d = radius_i;
      y_d = '0;
      err_d = '0;
      active_d = 1'b1;
    end else if (push_o) begin
      if (finish) begin
        active_d = 1'b0;
      end else begin
        y_d = y_q + COORD_W'(1);
        err_d = err_step;
        if ($signed(err_step) > $signed({{(ERR_W-COORD_W){1'b0}}, x_q})) begin
          err_d = err_step + ERR_W'(1) - {{(ERR_W-COORD_W-1){1'b0}}, x_q, 1'b0};
          x_d = x_q - COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      x_q <= '0;
      y_q <= '0;
      err_q <= '0;
      active_q <= 1'b0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      x_q <= x_d;
      y_q <= y_d;
      err_q <= err_d;
      active_q <= active_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/crc_queue.sv -----
`default_nettype none
module crc_queue #(
  parameter int unsigned Depth = crc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire crc_pkg::job_t push_data_i,
  input  wire logic          pop_i,
  output crc_pkg::job_t      head_o,
  output logic               empty_o,
  output logic               full_o
);
  import crc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign head_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o = (count_q == CntW'(Depth));

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count overflow");

endmodule
`default_nettype wire

// ----- hw/rtl/crc_back.sv -----
`default_nettype none
module crc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire crc_pkg::job_t               job_i,
  input  wire logic                        job_valid_i,
  output logic                             pop_o,
  input  wire crc_pkg::view_t              view_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [crc_pkg::COORD_W-1:0]      pixel_x_o,
  output logic [crc_pkg::COORD_W-1:0]      pixel_y_o,
  output logic                             visible_o,
  output logic [crc_pkg::OCT_W-1:0]        octant_o,
  output logic                             last_o,
  output logic                             done_res_o
);
  import crc_pkg::*;

  logic [OCT_W-1:0]   idx_q;
  logic               out_valid_q, out_free, emit, is_last;
  logic [COORD_W-1:0] col_off, row_off, col, row, px, py;
  logic [COORD_W-1:0] px_q, py_q;
  logic [OCT_W-1:0]   oct_q;
  logic               vis_q, last_q, done_q, vis;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit = out_free && job_valid_i;
  assign is_last = (idx_q == OCT_W'(NUM_OCTANTS - 1));
  assign pop_o = emit && is_last;

  // Pick the symmetric point: upper half swaps x and y, bit 1 mirrors col, bit 0 row
  assign col_off = idx_q[2] ? job_i.y : job_i.x;
  assign row_off = idx_q[2] ? job_i.x : job_i.y;
  assign col = idx_q[1] ? job_i.cx - col_off : job_i.cx + col_off;
  assign row = idx_q[0] ? job_i.cy - row_off : job_i.cy + row_off;
  assign px = col + view_i.area_x;
  assign py = row + view_i.area_y;
  assign vis = (px >= view_i.clip_left) && (px <= view_i.clip_right) &&
               (py >= view_i.clip_top) && (py <= view_i.clip_bottom);

  // Walk the octant index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        idx_q <= idx_q + OCT_W'(1);
      end
      if (out_free) begin
        out_valid_q <= job_valid_i;
      end
    end
  end

  // Load the output beat
  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q <= px;
      py_q <= py;
      vis_q <= vis;
      oct_q <= idx_q;
      last_q <= is_last;
      done_q <= is_last && job_i.finish;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;
  assign visible_o = vis_q;
  assign octant_o = oct_q;
  assign last_o = last_q;
  assign done_res_o = done_q;

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!done_q || (last_q && oct_q == OCT_W'(NUM_OCTANTS - 1))))
    else $error("done without last point");
  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> job_valid_i) else $error("pop without a job");

endmodule
`default_nettype wire
